FILE: rtl/ghbp_pkg.sv
// Shared types and constants for the global-history branch predictor.
package ghbp_pkg;

  // A 2-bit saturating prediction counter.
  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_MIN     = 2'd0;
  localparam ctr_t CTR_WEAK_NT = 2'd1;
  localparam ctr_t CTR_WEAK_T  = 2'd2;
  localparam ctr_t CTR_MAX     = 2'd3;

  // Configuration port layout.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LENGTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GSHARE_ENABLE  = 4'd1;

  // Field widths.
  localparam int HIST_LEN_W = 4;
  localparam int NIBBLE_W   = 4;

  localparam logic [HIST_LEN_W-1:0] HIST_LEN_RESET = 4'd4;

  // Moves a counter one step toward the resolved outcome, saturating at both ends.
  function automatic ctr_t ctr_update(input ctr_t ctr, input logic taken);
    ctr_t res;
    res = ctr;
    if (taken) begin
      if (ctr != CTR_MAX) res = ctr + 2'd1;
    end else begin
      if (ctr != CTR_MIN) res = ctr - 2'd1;
    end
    return res;
  endfunction

  // Taken when the counter is in one of its two upper states.
  function automatic logic ctr_predict(input ctr_t ctr);
    return (ctr >= CTR_WEAK_T);
  endfunction

endpackage

FILE: rtl/ghbp_in_if.sv
// Input channel carrying one resolved branch.
interface ghbp_in_if import ghbp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [NIBBLE_W-1:0] address_nibble;
  logic                taken;

  modport source (output valid, output address_nibble, output taken, input ready);
  modport sink   (input valid, input address_nibble, input taken, output ready);
endinterface

FILE: rtl/ghbp_out_if.sv
// Result channel carrying one prediction outcome.
interface ghbp_out_if ();
  logic valid;
  logic ready;
  logic predicted_taken;
  logic prediction_correct;

  modport source (output valid, output predicted_taken, output prediction_correct,
                  input ready);
  modport sink   (input valid, input predicted_taken, input prediction_correct,
                  output ready);
endinterface

FILE: rtl/ghbp_cfg_if.sv
// Configuration write channel: register index and write data.
interface ghbp_cfg_if import ghbp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/ghbp_ctr_mem.sv
// Counter table: one write port and one read port with registered read data.
module ghbp_ctr_mem import ghbp_pkg::*; #(
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  ctr_t              wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output ctr_t              rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  ctr_t mem [DEPTH];
  ctr_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/global_history_branch_predictor_unit.sv
// Top level of the global-history (gshare) branch predictor with 2-bit counters.
//
// Each input transfer is one resolved branch (address nibble and outcome). The
// block indexes a table of 2^MAX_HISTORY_BITS two-bit counters with the global
// history, masked to the configured length and XORed with the nibble when gshare
// mode is on, reports the counter's prediction and whether it matched, then
// steps the counter toward the outcome and shifts the outcome into the history.
// Throughput is one branch per clock cycle while the receiver takes results and
// no clearing pass runs; a result passes the read register of the counter table
// (stage one) and then the output register before it is offered. A counter
// written by one branch is forwarded to the next branch when both use the same
// entry. After reset the block runs a clearing pass that sets every counter to
// weakly not taken, one entry per cycle, so no input is taken until the pass
// ends; configuration writes are taken at any time.
module global_history_branch_predictor_unit import ghbp_pkg::*; #(
  parameter int MAX_HISTORY_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  ghbp_in_if.sink     in_ch,
  ghbp_out_if.source  out_ch,
  ghbp_cfg_if.sink    cfg_ch
);

  localparam int IDX_W   = MAX_HISTORY_BITS;
  localparam int LEN_W   = 5;
  localparam int NIB_X_W = (IDX_W > NIBBLE_W) ? IDX_W : NIBBLE_W;

  typedef logic [IDX_W-1:0] idx_t;

  // Configuration registers.
  logic [HIST_LEN_W-1:0] hist_len_r;
  logic                  gshare_r;

  // History and derived mask.
  idx_t             hist_r;
  idx_t             hist_mask;
  logic [LEN_W-1:0] eff_len;

  // Clearing pass.
  logic clr_active_r;
  idx_t clr_addr_r;

  // Stage one: item waiting on the table read.
  logic s1_valid_r;
  idx_t s1_idx_r;
  logic s1_taken_r;
  logic fwd_hit_r;
  ctr_t fwd_val_r;

  // Output register.
  logic out_valid_r;
  logic pred_r;
  logic corr_r;

  logic               in_fire;
  logic               s1_adv;
  idx_t               rd_idx;
  logic [NIB_X_W-1:0] nib_x;
  ctr_t               rdata;
  ctr_t               ctr_cur;
  ctr_t               ctr_new;
  logic               s1_pred;
  logic               mem_we;
  idx_t               mem_waddr;
  ctr_t               mem_wdata;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_len_r <= HIST_LEN_RESET;
      gshare_r   <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_HISTORY_LENGTH: hist_len_r <= cfg_ch.data[HIST_LEN_W-1:0];
        REG_GSHARE_ENABLE:  gshare_r   <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // A length of zero acts as one, and a length beyond the table width is clipped.
  always_comb begin
    eff_len = LEN_W'(hist_len_r);
    if (hist_len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (LEN_W'(hist_len_r) > LEN_W'(MAX_HISTORY_BITS)) begin
      eff_len = LEN_W'(MAX_HISTORY_BITS);
    end
    for (int i = 0; i < IDX_W; i++) begin
      hist_mask[i] = (LEN_W'(i) < eff_len);
    end
  end

  // The nibble only enters the index, never the history. When the table is
  // narrower than a nibble the upper nibble bits fall off the index.
  assign nib_x  = NIB_X_W'(in_ch.address_nibble);
  assign rd_idx = (hist_r & hist_mask) ^ (gshare_r ? nib_x[IDX_W-1:0] : '0);

  // Stage one leaves when the output register is free or being drained.
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !clr_active_r && (!s1_valid_r || s1_adv);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // The item ahead writes its entry at the same edge this item reads it; in
  // that case the read returns stale data and the written value is used instead.
  assign ctr_cur = fwd_hit_r ? fwd_val_r : rdata;
  assign ctr_new = ctr_update(ctr_cur, s1_taken_r);
  assign s1_pred = ctr_predict(ctr_cur);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (in_fire) begin
      hist_r <= (((hist_r & hist_mask) << 1) | IDX_W'(in_ch.taken)) & hist_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + IDX_W'(1);
      if (clr_addr_r == '1) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx_r   <= rd_idx;
      s1_taken_r <= in_ch.taken;
      fwd_hit_r  <= s1_adv && (s1_idx_r == rd_idx);
      fwd_val_r  <= ctr_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pred_r <= s1_pred;
      corr_r <= (s1_pred == s1_taken_r);
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.predicted_taken    = pred_r;
  assign out_ch.prediction_correct = corr_r;

  // The clearing pass owns the write port until it ends.
  always_comb begin
    if (clr_active_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = CTR_WEAK_NT;
    end else begin
      mem_we    = s1_adv;
      mem_waddr = s1_idx_r;
      mem_wdata = ctr_new;
    end
  end

  ghbp_ctr_mem #(
    .ADDR_W (IDX_W)
  ) u_ctr_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_fire),
    .raddr (rd_idx),
    .rdata (rdata)
  );

endmodule

FILE: dv/tb_global_history_branch_predictor_unit.sv
// Self-checking testbench for the global-history branch predictor unit.
`timescale 1ns / 100ps

module tb_global_history_branch_predictor_unit import ghbp_pkg::*; ();

  localparam int MAX_HISTORY_BITS = 10;
  localparam int TABLE_ENTRIES    = 1 << MAX_HISTORY_BITS;
  localparam int CYCLE_LIMIT      = 200000;

  // Register indexes that the block must ignore.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = 4'd15;

  // What one resolved branch is expected to report.
  typedef struct packed {
    logic predicted_taken;
    logic prediction_correct;
  } branch_outcome_t;

  // Tracks the predictor's history register and counter table on its own and
  // holds the outcomes that are still owed by the block, oldest first.
  class branch_scoreboard;
    logic [HIST_LEN_W-1:0]       hist_len;
    logic                        gshare_on;
    logic [MAX_HISTORY_BITS-1:0] history;
    ctr_t                        counters [TABLE_ENTRIES];
    branch_outcome_t             outcome_q [$];
    int                          errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      hist_len  = HIST_LEN_RESET;
      gshare_on = 1'b0;
      history   = '0;
      foreach (counters[i]) counters[i] = CTR_WEAK_NT;
      outcome_q.delete();
    endfunction

    function void apply_write(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_HISTORY_LENGTH: hist_len = data;
        REG_GSHARE_ENABLE:  gshare_on = data[0];
        default: ;
      endcase
    endfunction

    // A length of zero acts as one and anything past the table width is clipped.
    function logic [MAX_HISTORY_BITS-1:0] length_mask();
      int len;
      len = hist_len;
      if (len < 1) len = 1;
      if (len > MAX_HISTORY_BITS) len = MAX_HISTORY_BITS;
      return MAX_HISTORY_BITS'((1 << len) - 1);
    endfunction

    function void note_branch(input logic [NIBBLE_W-1:0] nib, input logic tk);
      logic [MAX_HISTORY_BITS-1:0] mask;
      logic [MAX_HISTORY_BITS-1:0] idx;
      ctr_t                        ctr;
      branch_outcome_t             res;
      mask = length_mask();
      idx  = history & mask;
      // The nibble only shapes the index; it never enters the history.
      if (gshare_on) idx = idx ^ MAX_HISTORY_BITS'(nib);
      ctr = counters[idx];
      res.predicted_taken    = (ctr >= CTR_WEAK_T);
      res.prediction_correct = (res.predicted_taken == tk);
      if (tk) begin
        if (ctr != CTR_MAX) ctr = ctr + 2'd1;
      end else begin
        if (ctr != CTR_MIN) ctr = ctr - 2'd1;
      end
      counters[idx] = ctr;
      history = ((history & mask) << 1 | MAX_HISTORY_BITS'(tk)) & mask;
      outcome_q.push_back(res);
    endfunction

    function void check_outcome(input logic pred, input logic corr);
      branch_outcome_t exp;
      if (outcome_q.size() == 0) begin
        $display("%0t: result with nothing outstanding: predicted_taken %b prediction_correct %b",
                 $time, pred, corr);
        errors++;
        return;
      end
      exp = outcome_q.pop_front();
      if (pred !== exp.predicted_taken) begin
        $display("%0t: predicted_taken expected %b actual %b",
                 $time, exp.predicted_taken, pred);
        errors++;
      end
      if (corr !== exp.prediction_correct) begin
        $display("%0t: prediction_correct expected %b actual %b",
                 $time, exp.prediction_correct, corr);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  int   send_idle_pct;
  int   recv_idle_pct;

  branch_scoreboard sb;

  ghbp_in_if  in_ch ();
  ghbp_out_if out_ch ();
  ghbp_cfg_if cfg_ch ();

  global_history_branch_predictor_unit #(
    .MAX_HISTORY_BITS(MAX_HISTORY_BITS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // All transfers are observed here, at the clock edge, from values that were
  // settled before the edge. Configuration writes happen only while nothing is
  // in flight, so their order against branch transfers never matters.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
        sb.apply_write(cfg_ch.index, cfg_ch.data);
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        sb.note_branch(in_ch.address_nibble, in_ch.taken);
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        sb.check_outcome(out_ch.predicted_taken, out_ch.prediction_correct);
      end
    end
  end

  // The receiver stalls at random, one decision per cycle.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog. The slowest legal run (clearing pass, sender gaps and receiver
  // stalls on every branch) stays far below this bound.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offers one branch and returns at the edge where it transfers. Valid is
  // left high so the next branch can follow without a bubble; a random gap is
  // opened by lowering it in a later cycle.
  task automatic send_branch(input logic [NIBBLE_W-1:0] nib, input logic tk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.address_nibble <= nib;
    in_ch.taken          <= tk;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // The write's valid is dropped at its transfer edge and the task then waits for
  // another clock edge before it returns, so back-to-back writes never touch valid twice in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Every branch yields exactly one result, so the block is idle once the
  // last outstanding outcome has been checked.
  task automatic wait_for_quiet();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.outcome_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Sets both registers and pokes one unused index, which must change nothing.
  task automatic configure(input logic [HIST_LEN_W-1:0] len,
                           input logic [CFG_DATA_W-1:0] gshare_data);
    write_reg(REG_HISTORY_LENGTH, len);
    write_reg(REG_GSHARE_ENABLE, gshare_data);
    write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
              CFG_DATA_W'($urandom));
  endtask

  // Mostly loop-like branch streams: a short repeating outcome pattern with a
  // fixed nibble per slot, which trains the counters the way real code does.
  // One branch in five is pure noise, and the pattern changes now and then.
  task automatic run_segment(input int n);
    int                  period;
    int                  slot;
    logic [7:0]          pattern;
    logic [NIBBLE_W-1:0] nibs [8];
    period = 1;
    pattern = '0;
    for (int i = 0; i < n; i++) begin
      if (i % 48 == 0) begin
        period  = $urandom_range(1, 8);
        pattern = 8'($urandom);
        foreach (nibs[k]) nibs[k] = NIBBLE_W'($urandom);
      end
      slot = i % period;
      if ($urandom_range(99) < 20) begin
        send_branch(NIBBLE_W'($urandom), 1'($urandom));
      end else begin
        send_branch(nibs[slot], pattern[slot]);
      end
    end
  endtask

  // History lengths per random segment, extremes and out-of-range values among
  // them (zero acts as one, fifteen as the full table width).
  int seg_len [13] = '{1, 10, 0, 15, 4, 7, 2, 12, 9, 10, 1, 5, 3};

  initial begin
    sb = new();
    send_idle_pct = 17;
    recv_idle_pct = 64;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.address_nibble <= '0;
    in_ch.taken          <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= '0;
    cfg_ch.data          <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset configuration (four history bits, no gshare).
    // A run of taken branches drives the all-ones-history counter to its top;
    // the block is still in its clearing pass at first, which the handshake absorbs.
    repeat (6) send_branch(4'd0, 1'b1);
    // A run of not-taken branches drives the all-zero-history counter to its bottom.
    repeat (6) send_branch(4'd15, 1'b0);
    wait_for_quiet();

    // Length zero behaves as a single history bit; gshare on with every data
    // bit set, then unused index 2 written with all ones and index 15 with zeros.
    write_reg(REG_HISTORY_LENGTH, 4'd0);
    write_reg(REG_GSHARE_ENABLE, 4'hF);
    write_reg(REG_UNUSED_FIRST, 4'hF);
    write_reg(REG_UNUSED_LAST, 4'h0);
    send_branch(4'd15, 1'b1);
    send_branch(4'd0, 1'b0);
    send_branch(4'd10, 1'b1);
    send_branch(4'd5, 1'b0);
    send_branch(4'd15, 1'b1);
    wait_for_quiet();

    // A length above the table width is clipped; history left over from the
    // shorter setting must be masked on the way in.
    configure(4'd15, 4'h0);
    repeat (4) send_branch(4'd9, 1'b1);
    send_branch(4'd6, 1'b0);
    wait_for_quiet();

    // Random part in three idling regimes: sender light and receiver heavy,
    // then the reverse, then both sides at full rate.
    for (int seg = 0; seg < 13; seg++) begin
      if (seg == 5) begin
        send_idle_pct = 64;
        recv_idle_pct = 17;
      end else if (seg == 9) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      configure(HIST_LEN_W'(seg_len[seg]),
                CFG_DATA_W'(($urandom_range(7) << 1) | (seg % 2)));
      run_segment(150);
      wait_for_quiet();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
